/* hw/rtl/roman_numeral_encoder_assert.svh */
// ----------------------------------------------------------------------------
// roman numeral encoder assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RNE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define RNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rne_pkg.sv */
// ----------------------------------------------------------------------------
// rne_pkg
// shared types, constants and letter table of the roman numeral encoder
// ----------------------------------------------------------------------------
package rne_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int VALUE_W     = 16;
	localparam int BIN_W       = 12;
	localparam int BCD_W       = 4 * DIGIT_COUNT;
	localparam int SYM_W       = 7;
	localparam int CONV_STEPS  = BIN_W / 2;
	localparam int CNT_W       = 3;
	localparam logic [VALUE_W-1:0] MAX_VALUE = 16'd3999;

	// letters by decade: one, five, ten per position, padded above m
	localparam logic [SYM_W-1:0] LETTER_TABLE [9] = '{
		7'h49, 7'h56, 7'h58, 7'h4C, 7'h43, 7'h44, 7'h4D, 7'h00, 7'h00
	};

	typedef enum logic [1:0] {
		LK_ONE  = 2'd0,
		LK_FIVE = 2'd1,
		LK_TEN  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	// number of letters that one decimal digit produces
	function automatic logic [2:0] pattern_len(input logic [3:0] d);
		logic [2:0] n;
		unique case (d)
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// which letter of the decade a given step of a digit uses
	function automatic kind_t letter_kind(input logic [3:0] d, input logic [2:0] step);
		kind_t k;
		priority if (d == 4'd9) begin
			k = (step == 3'd0) ? LK_ONE : LK_TEN;
		end else if (d == 4'd4) begin
			k = (step == 3'd0) ? LK_ONE : LK_FIVE;
		end else if (d >= 4'd5) begin
			k = (step == 3'd0) ? LK_FIVE : LK_ONE;
		end else begin
			k = LK_ONE;
		end
		return k;
	endfunction

endpackage

/* hw/rtl/rne_if.sv */
// ----------------------------------------------------------------------------
// rne channel interfaces
// valid/ready channels for input values and output letters
// ----------------------------------------------------------------------------
interface rne_num_if;
	logic                        valid;
	logic                        ready;
	logic [rne_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rne_letter_if;
	logic                      valid;
	logic                      ready;
	logic [rne_pkg::SYM_W-1:0] symbol;
	logic                      last;
	logic                      range_error;

	modport source (output valid, output symbol, output last, output range_error, input ready);
	modport sink   (input valid, input symbol, input last, input range_error, output ready);
endinterface

/* hw/rtl/rne_datapath.sv */
// ----------------------------------------------------------------------------
// rne_datapath
// binary to bcd conversion, letter selection and output register
// ----------------------------------------------------------------------------
module rne_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rne_pkg::VALUE_W-1:0] value,
	input  rne_pkg::cmd_t               cmd,
	output rne_pkg::sts_t               sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rne_pkg::SYM_W-1:0]   symbol,
	output logic                        last,
	output logic                        range_error
);

	logic [rne_pkg::BIN_W-1:0] bin_q;
	logic [rne_pkg::BCD_W-1:0] bcd_q;
	logic                      err_q;
	logic [1:0]                pos_q;
	logic [2:0]                step_q;
	logic                      ovalid_q;
	logic [rne_pkg::SYM_W-1:0] osym_q;
	logic                      olast_q;
	logic                      oerr_q;

	logic [3:0]                dig [rne_pkg::DIGIT_COUNT];
	logic [3:0]                d;
	logic [2:0]                len;
	logic                      step_end;
	logic                      lower_zero;
	logic                      is_last;
	logic                      slot_free;
	logic                      fire;
	logic                      produce;
	logic                      bad;
	rne_pkg::kind_t            kind;
	logic [3:0]                idx;
	logic [rne_pkg::SYM_W-1:0] letter;
	logic [rne_pkg::BIN_W-1:0] bin_d;
	logic [rne_pkg::BCD_W-1:0] bcd_d;

	for (genvar g = 0; g < rne_pkg::DIGIT_COUNT; g++) begin : g_dig
		assign dig[g] = bcd_q[4*g +: 4];
	end

	assign bad = (value == '0) || (value > rne_pkg::MAX_VALUE);

	// double dabble, two bits per cycle
	always_comb begin
		bin_d = bin_q;
		bcd_d = bcd_q;
		for (int b = 0; b < 2; b++) begin
			for (int i = 0; i < rne_pkg::DIGIT_COUNT; i++) begin
				if (bcd_d[4*i +: 4] >= 4'd5) begin
					bcd_d[4*i +: 4] = bcd_d[4*i +: 4] + 4'd3;
				end
			end
			bcd_d = {bcd_d[rne_pkg::BCD_W-2:0], bin_d[rne_pkg::BIN_W-1]};
			bin_d = {bin_d[rne_pkg::BIN_W-2:0], 1'b0};
		end
	end

	always_comb begin
		lower_zero = 1'b1;
		for (int i = 0; i < rne_pkg::DIGIT_COUNT; i++) begin
			if ((2'(i) < pos_q) && (dig[i] != 4'd0)) begin
				lower_zero = 1'b0;
			end
		end
	end

	assign d         = dig[pos_q];
	assign len       = rne_pkg::pattern_len(d);
	assign step_end  = (step_q == (len - 3'd1));
	assign kind      = rne_pkg::letter_kind(d, step_q);
	assign idx       = {1'b0, pos_q, 1'b0} + {2'b00, kind};
	assign letter    = rne_pkg::LETTER_TABLE[idx];
	assign is_last   = err_q || (step_end && lower_zero);
	assign slot_free = !ovalid_q || out_ready;
	assign fire      = cmd.emit && slot_free;
	assign produce   = fire && (err_q || (len != 3'd0));
	assign sts.done  = produce && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			pos_q    <= '0;
			step_q   <= '0;
			err_q    <= 1'b0;
		end else begin
			if (produce) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.load) begin
				err_q  <= bad;
				pos_q  <= 2'(rne_pkg::DIGIT_COUNT - 1);
				step_q <= '0;
			end else if (fire && !err_q) begin
				if ((len == 3'd0) || step_end) begin
					pos_q  <= pos_q - 2'd1;
					step_q <= '0;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= bad ? '0 : value[rne_pkg::BIN_W-1:0];
			bcd_q <= '0;
		end else if (cmd.conv) begin
			bin_q <= bin_d;
			bcd_q <= bcd_d;
		end
		if (produce) begin
			osym_q  <= err_q ? '0 : letter;
			olast_q <= is_last;
			oerr_q  <= err_q;
		end
	end

	assign out_valid   = ovalid_q;
	assign symbol      = osym_q;
	assign last        = olast_q;
	assign range_error = oerr_q;

endmodule

/* hw/rtl/rne_ctrl.sv */
// ----------------------------------------------------------------------------
// rne_ctrl
// sequencer: accept, convert to decimal, emit letters
// ----------------------------------------------------------------------------
module rne_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output rne_pkg::cmd_t cmd,
	input  rne_pkg::sts_t sts
);

	rne_pkg::state_t                state_q;
	logic [rne_pkg::CNT_W-1:0]      cnt_q;

	assign in_ready = (state_q == rne_pkg::ST_IDLE);
	assign cmd.load = in_ready && in_valid;
	assign cmd.conv = (state_q == rne_pkg::ST_CONV);
	assign cmd.emit = (state_q == rne_pkg::ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rne_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				rne_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= rne_pkg::ST_CONV;
						cnt_q   <= '0;
					end
				end
				rne_pkg::ST_CONV: begin
					cnt_q <= cnt_q + rne_pkg::CNT_W'(1);
					if (cnt_q == rne_pkg::CNT_W'(rne_pkg::CONV_STEPS - 1)) begin
						state_q <= rne_pkg::ST_EMIT;
					end
				end
				rne_pkg::ST_EMIT: begin
					if (sts.done) begin
						state_q <= rne_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rne_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/roman_numeral_encoder.sv */
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// binary integer in, roman numeral out as a run of ascii letters
// ----------------------------------------------------------------------------
// usage
// - num channel: one 16-bit value per transaction, taken when valid and
//   ready are both high; ready is high only while the block is idle
// - letter channel: one ascii letter per transaction, thousands first,
//   subtractive forms used; last marks the final letter of a value's run
// - a value of 0 or above 3999 gives one transaction with symbol 0,
//   last and range_error set
// - sequence: accept, then binary to bcd conversion (two bits per cycle
//   through the shift-and-add-3 unit), then the letters in order; zero
//   digits above the last nonzero one are passed over without a letter
// - a new value is taken only after the final letter of the previous
//   value has been loaded into the output register
// - a stalled receiver holds the output register; emission pauses until
//   the letter is taken, nothing is dropped
// - reset clears the sequencer and the output valid; the block comes up
//   idle and ready
// ----------------------------------------------------------------------------
`include "roman_numeral_encoder_assert.svh"

module roman_numeral_encoder (
	input logic          clk,
	input logic          arst_n,
	rne_num_if.sink      num,
	rne_letter_if.source letter
);

	rne_pkg::cmd_t cmd;
	rne_pkg::sts_t sts;

	// sequencer
	rne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (num.valid),
		.in_ready (num.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// conversion and letter output
	rne_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (num.value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (letter.valid),
		.out_ready   (letter.ready),
		.symbol      (letter.symbol),
		.last        (letter.last),
		.range_error (letter.range_error)
	);

	// an error result is a lone, marked, blank letter
	`RNE_ASSERT_IMPLY(a_err_form, letter.valid && letter.range_error, letter.last && (letter.symbol == '0), "range error result malformed")
	// a valid run never carries a blank letter
	`RNE_ASSERT_IMPLY(a_letter_nonzero, letter.valid && !letter.range_error, letter.symbol != '0, "blank letter in valid run")
	// a new value is never taken back to back
	`RNE_ASSERT_NEXT(a_one_at_a_time, num.valid && num.ready, !num.ready, "input accepted while busy")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for roman_numeral_encoder: a short table of directed
// values, some with the letters typed in, then a random mix of valid and
// out-of-range values, all other letters predicted in the bench and
// compared in order, with random idle bursts on both channels
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_VALUES = 250;
	localparam int CALM_TAIL     = 40;
	localparam int MAX_REPORTS   = 10;

	// one, five, ten letters per decade; nothing exists above m
	localparam logic [7:0] DECADE_LETTERS [9] = '{
		"I", "V", "X", "L", "C", "D", "M", 8'h00, 8'h00
	};

	// one expected letter transaction, tagged with the value it came from
	typedef struct {
		logic [rne_pkg::SYM_W-1:0]   symbol;
		logic                        last;
		logic                        range_error;
		logic [rne_pkg::VALUE_W-1:0] from_value;
	} letter_t;

	// a directed row: typed rows carry their letters or an error mark
	typedef struct {
		logic [rne_pkg::VALUE_W-1:0] value;
		bit                          typed;
		bit                          rejected;
		string                       spelled;
	} probe_t;

	logic clk;
	logic arst_n;

	rne_num_if    num_ch ();
	rne_letter_if letter_ch ();

	roman_numeral_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.letter (letter_ch)
	);

	letter_t pending_letters [$];
	int      mismatches = 0;
	int      gap_pct    = 0;
	int      stall_pct  = 0;

	// extremes and out-of-range values typed in; every digit shape comes
	// from the predictor
	probe_t probes [25] = '{
		'{16'd0,     1'b1, 1'b1, ""},
		'{16'd1,     1'b1, 1'b0, "I"},
		'{16'd3,     1'b0, 1'b0, ""},
		'{16'd4,     1'b0, 1'b0, ""},
		'{16'd5,     1'b0, 1'b0, ""},
		'{16'd8,     1'b0, 1'b0, ""},
		'{16'd9,     1'b0, 1'b0, ""},
		'{16'd40,    1'b0, 1'b0, ""},
		'{16'd90,    1'b0, 1'b0, ""},
		'{16'd400,   1'b0, 1'b0, ""},
		'{16'd900,   1'b0, 1'b0, ""},
		'{16'd1000,  1'b0, 1'b0, ""},
		'{16'd3000,  1'b0, 1'b0, ""},
		'{16'd3888,  1'b1, 1'b0, "MMMDCCCLXXXVIII"},
		'{16'd3999,  1'b1, 1'b0, "MMMCMXCIX"},
		'{16'd4000,  1'b1, 1'b1, ""},
		'{16'd32768, 1'b1, 1'b1, ""},
		'{16'd65535, 1'b1, 1'b1, ""},
		'{16'd14,    1'b0, 1'b0, ""},
		'{16'd49,    1'b0, 1'b0, ""},
		'{16'd444,   1'b0, 1'b0, ""},
		'{16'd999,   1'b0, 1'b0, ""},
		'{16'd1994,  1'b0, 1'b0, ""},
		'{16'd2707,  1'b0, 1'b0, ""},
		'{16'd1010,  1'b0, 1'b0, ""}
	};

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// queue a run of letters for one value, marking the final one
	function automatic void queue_run(input logic [7:0] word [$],
			input logic [rne_pkg::VALUE_W-1:0] v);
		letter_t l;
		for (int i = 0; i < word.size(); i++) begin
			l.symbol      = word[i][rne_pkg::SYM_W-1:0];
			l.last        = (i == word.size() - 1);
			l.range_error = 1'b0;
			l.from_value  = v;
			pending_letters.push_back(l);
		end
	endfunction

	// a rejected value gives a single flagged transaction with symbol 0
	function automatic void queue_rejection(input logic [rne_pkg::VALUE_W-1:0] v);
		letter_t l;
		l.symbol      = '0;
		l.last        = 1'b1;
		l.range_error = 1'b1;
		l.from_value  = v;
		pending_letters.push_back(l);
	endfunction

	// predicted letters of one value, thousands digit first
	function automatic void spell_value(input logic [rne_pkg::VALUE_W-1:0] v);
		logic [7:0] word [$];
		logic [7:0] one, five, ten;
		int         digit [rne_pkg::DIGIT_COUNT];
		int         rest;
		if (v == 0 || v > rne_pkg::MAX_VALUE) begin
			queue_rejection(v);
			return;
		end
		rest = v;
		for (int p = 0; p < rne_pkg::DIGIT_COUNT; p++) begin
			digit[p] = rest % 10;
			rest     = rest / 10;
		end
		for (int p = rne_pkg::DIGIT_COUNT - 1; p >= 0; p--) begin
			one  = DECADE_LETTERS[2 * p];
			five = DECADE_LETTERS[2 * p + 1];
			ten  = DECADE_LETTERS[2 * p + 2];
			case (digit[p])
				9: begin
					word.push_back(one);
					word.push_back(ten);
				end
				4: begin
					word.push_back(one);
					word.push_back(five);
				end
				default: begin
					// five first for 5..8, then the ones
					if (digit[p] >= 5)
						word.push_back(five);
					repeat (digit[p] % 5)
						word.push_back(one);
				end
			endcase
		end
		queue_run(word, v);
	endfunction

	// directed row with typed letters
	function automatic void queue_typed(input probe_t row);
		logic [7:0] word [$];
		if (row.rejected) begin
			queue_rejection(row.value);
			return;
		end
		for (int i = 0; i < row.spelled.len(); i++)
			word.push_back(row.spelled[i]);
		queue_run(word, row.value);
	endfunction

	// offer one value and hold it until the transaction is taken; the
	// expected letters are queued at the accepting edge
	task automatic offer_value(input probe_t row);
		if ($urandom_range(0, 99) < gap_pct) begin
			num_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		num_ch.valid = 1'b1;
		num_ch.value = row.value;
		do
			@(posedge clk);
		while (!num_ch.ready);
		if (row.typed)
			queue_typed(row);
		else
			spell_value(row.value);
		@(negedge clk);
	endtask

	// random value: mostly valid, some zero, some too large
	function automatic logic [rne_pkg::VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return '0;
		else if (roll < 20)
			return rne_pkg::VALUE_W'($urandom_range(4000, 65535));
		else
			return rne_pkg::VALUE_W'($urandom_range(1, 3999));
	endfunction

	// letter receiver: random stall bursts while stall_pct is nonzero
	initial begin
		letter_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				letter_ch.ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			letter_ch.ready = 1'b1;
		end
	end

	// compare every letter transaction with the oldest expectation
	always @(posedge clk) begin : check_letter
		letter_t want;
		if (arst_n && letter_ch.valid && letter_ch.ready) begin
			if (pending_letters.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected letter symbol %h last %b range_error %b",
						$realtime, letter_ch.symbol, letter_ch.last, letter_ch.range_error);
			end else begin
				want = pending_letters.pop_front();
				if (letter_ch.symbol !== want.symbol || letter_ch.last !== want.last ||
						letter_ch.range_error !== want.range_error) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$write("%0t: value %0d: expected symbol %h last %b range_error %b,",
							$realtime, want.from_value, want.symbol, want.last,
							want.range_error);
						$display(" got symbol %h last %b range_error %b",
							letter_ch.symbol, letter_ch.last, letter_ch.range_error);
					end
				end
			end
		end
	end

	// main sequence
	initial begin
		probe_t row;
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table with moderate idling on both sides
		gap_pct   = 25;
		stall_pct = 25;
		foreach (probes[i])
			offer_value(probes[i]);

		// random values; idling level changes every 50 transactions and
		// the tail runs with none
		row.typed    = 1'b0;
		row.rejected = 1'b0;
		row.spelled  = "";
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			if (i >= RANDOM_VALUES - CALM_TAIL) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if (i % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			row.value = pick_value();
			offer_value(row);
		end
		num_ch.valid = 1'b0;

		// drain, then give the block time to show any stray letter
		while (pending_letters.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0 && pending_letters.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
